// File: rtl/lci_pkg.sv
// Shared types, widths and helpers for the line/circle intersection pipeline.
// No dependencies.
package lci_pkg;

   // Field widths of one item
   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 31;

   // Internal widths. All ranges are exact for 32 bit operands.
   localparam int CP_W     = 66;   // shifted line constant, signed
   localparam int Q_W      = 64;   // a*a + b*b
   localparam int RR_W     = 62;   // r*r
   localparam int ROOT_W   = 63;   // floor sqrt of the discriminant
   localparam int D_W      = 131;  // discriminant, signed
   localparam int QUO_W    = 32;   // quotient magnitude, |offset| < 2*r
   localparam int NUM_W    = 99;   // signed numerators before division
   localparam int MUL_LAT  = 3;    // latency of lci_mul

   localparam logic [COORD_W-1:0] COORD_NONE = '1;
   localparam logic [COORD_W-1:0] COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_TANGENT  = 2'd1,
      STATUS_TWO      = 2'd2,
      STATUS_VERTICAL = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] line_a;
      logic signed [COORD_W-1:0] line_b;
      logic signed [COORD_W-1:0] line_c;
      logic signed [COORD_W-1:0] centre_x;
      logic signed [COORD_W-1:0] centre_y;
      logic [RADIUS_W-1:0]       radius;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic                      saturated;
   } rsp_type;

   // Clip a 34 bit sum to the coordinate range; bit 32 of the result flags a clip.
   function automatic logic [COORD_W:0] clip_coord(input logic [COORD_W+1:0] v);
      logic sat;
      sat = !((v[COORD_W+1:COORD_W-1] == 3'b000) || (v[COORD_W+1:COORD_W-1] == 3'b111));
      if (sat) begin
         clip_coord = {1'b1, (v[COORD_W+1] ? COORD_MIN : COORD_MAX)};
      end else begin
         clip_coord = {1'b0, v[COORD_W-1:0]};
      end
   endfunction

endpackage

// File: rtl/lci_delay.sv
// Fixed-length delay line with a reset valid lane and an unreset data lane.
// No dependencies.
module lci_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             valid_in,
   input  logic [WIDTH-1:0] data_in,
   output logic             valid_out,
   output logic [WIDTH-1:0] data_out
);

   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= DEPTH'({valid_ff, valid_in});
      end
   end

   always_ff @(posedge clock) begin
      data_ff[0] <= data_in;
      for (int k = 1; k < DEPTH; k++) begin
         data_ff[k] <= data_ff[k-1];
      end
   end

   assign valid_out = valid_ff[DEPTH-1];
   assign data_out  = data_ff[DEPTH-1];

endmodule

// File: rtl/lci_mul.sv
// Three-stage unsigned multiplier built from 32x32 limb products, sign applied last.
// No dependencies.
module lci_mul #(
   parameter int A_W = 64,
   parameter int B_W = 64
) (
   input  logic                  clock,
   input  logic [A_W-1:0]        a_mag,
   input  logic [B_W-1:0]        b_mag,
   input  logic                  negate,
   output logic signed [A_W+B_W:0] product
);

   localparam int LIMB    = 32;
   localparam int NA      = (A_W + LIMB - 1) / LIMB;
   localparam int NB      = (B_W + LIMB - 1) / LIMB;
   localparam int A_PAD_W = NA * LIMB;
   localparam int B_PAD_W = NB * LIMB;
   localparam int ROW_W   = B_PAD_W + LIMB;
   localparam int FULL_W  = A_PAD_W + B_PAD_W;
   localparam int MAG_W   = A_W + B_W;
   localparam int OUT_W   = A_W + B_W + 1;

   logic [A_PAD_W-1:0] a_pad;
   logic [B_PAD_W-1:0] b_pad;
   logic [2*LIMB-1:0]  part_ff [NA][NB];
   logic [ROW_W-1:0]   row_in  [NA];
   logic [ROW_W-1:0]   row_ff  [NA];
   logic               neg_s1_ff, neg_s2_ff;
   logic [FULL_W-1:0]  total;
   logic [OUT_W-1:0]   mag_ext;
   logic [OUT_W-1:0]   product_ff;

   assign a_pad = A_PAD_W'(a_mag);
   assign b_pad = B_PAD_W'(b_mag);

   // stage 1: limb products
   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            part_ff[i][j] <= a_pad[i*LIMB +: LIMB] * b_pad[j*LIMB +: LIMB];
         end
      end
      neg_s1_ff <= negate;
   end

   // stage 2: one row per limb of a
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (ROW_W'(part_ff[i][j]) << (j*LIMB));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         row_ff[i] <= row_in[i];
      end
      neg_s2_ff <= neg_s1_ff;
   end

   // stage 3: rows summed, sign applied
   always_comb begin
      total = '0;
      for (int i = 0; i < NA; i++) begin
         total = total + (FULL_W'(row_ff[i]) << (i*LIMB));
      end
      mag_ext = {1'b0, total[MAG_W-1:0]};
   end

   always_ff @(posedge clock) begin
      product_ff <= neg_s2_ff ? (~mag_ext + OUT_W'(1)) : mag_ext;
   end

   assign product = $signed(product_ff);

endmodule

// File: rtl/lci_sqrt.sv
// Pipelined floor square root, one result bit per stage.
// No dependencies.
module lci_sqrt #(
   parameter int ROOT_W = 63
) (
   input  logic                  clock,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic [ROOT_W-1:0]     root
);

   localparam int REM_W = ROOT_W + 2;

   logic [REM_W-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [2*ROOT_W-1:0] rest_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic [REM_W-1:0]    rem_prev;
      logic [ROOT_W-1:0]   root_prev;
      logic [2*ROOT_W-1:0] rest_prev;
      logic [REM_W+1:0]    rem_sh, trial, diff;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rest_prev = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rest_prev = rest_ff[k-1];
      end

      assign rem_sh = {rem_prev, rest_prev[2*ROOT_W-1 -: 2]};
      assign trial  = (REM_W+2)'({root_prev, 2'b01});
      assign diff   = rem_sh - trial;

      always_ff @(posedge clock) begin
         if (rem_sh >= trial) begin
            rem_ff[k]  <= diff[REM_W-1:0];
            root_ff[k] <= {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff[k]  <= rem_sh[REM_W-1:0];
            root_ff[k] <= {root_prev[ROOT_W-2:0], 1'b0};
         end
         rest_ff[k] <= rest_prev << 2;
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

// File: rtl/lci_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Dividend must be below divisor * 2^QUO_W. No dependencies.
module lci_div #(
   parameter int QUO_W = 32,
   parameter int DEN_W = 64
) (
   input  logic                    clock,
   input  logic [DEN_W+QUO_W-1:0]  dividend,
   input  logic [DEN_W-1:0]        divisor,
   output logic [QUO_W-1:0]        quotient
);

   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [DEN_W-1:0] rem_prev, den_prev;
      logic [QUO_W-1:0] low_prev, quo_prev;
      logic [DEN_W:0]   rem_sh, diff;

      if (k == 0) begin : g_first
         assign rem_prev = dividend[DEN_W+QUO_W-1:QUO_W];
         assign low_prev = dividend[QUO_W-1:0];
         assign den_prev = divisor;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign rem_sh = {rem_prev, low_prev[QUO_W-1]};
      assign diff   = rem_sh - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (rem_sh >= {1'b0, den_prev}) begin
            rem_ff[k] <= diff[DEN_W-1:0];
            quo_ff[k] <= {quo_prev[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff[k] <= rem_sh[DEN_W-1:0];
            quo_ff[k] <= {quo_prev[QUO_W-2:0], 1'b0};
         end
         low_ff[k] <= low_prev << 1;
         den_ff[k] <= den_prev;
      end
   end

   assign quotient = quo_ff[QUO_W-1];

endmodule

// File: rtl/line_circle_intersection.sv
// Line/circle intersection top level: fully pipelined, one item per clock.
// Depends on lci_pkg, lci_delay, lci_mul, lci_sqrt, lci_div.
//
// Takes a line a*x+b*y+c=0 and a circle (centre, radius) in signed fixed point
// with FRAC_BITS fraction bits and returns the crossing points. busy is always
// low: an item is taken on every edge with start high, and its result appears
// on rsp_data with rsp_strobe high for one cycle. The receiver cannot hold
// results off and none is needed, since every item in flight moves one stage
// per clock. The pipeline spans the 63-stage square root of the discriminant,
// the 32-stage dividers (one quotient bit each), two 3-stage wide multipliers
// and the input, product, setup, discriminant, numerator and output stages.
// Status: none (-1 coordinates), tangent (second point copies the first), two
// points (+sqrt root first), or vertical line (b == 0, unsupported, -1
// coordinates). Coordinates out of the 32 bit range clip and set saturated.
module line_circle_intersection #(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  lci_pkg::req_type req_data,
   output logic            rsp_strobe,
   output lci_pkg::rsp_type rsp_data
);

   localparam int CW     = lci_pkg::COORD_W;
   localparam int CP_W   = lci_pkg::CP_W;
   localparam int Q_W    = lci_pkg::Q_W;
   localparam int RR_W   = lci_pkg::RR_W;
   localparam int ROOT_W = lci_pkg::ROOT_W;
   localparam int D_W    = lci_pkg::D_W;
   localparam int QUO_W  = lci_pkg::QUO_W;
   localparam int NUM_W  = lci_pkg::NUM_W;
   localparam int CPM_W  = CP_W - 1;          // |cp| magnitude
   localparam int ACP_W  = CW + CPM_W + 1;    // signed a*cp
   localparam int AS_W   = CW + ROOT_W + 1;   // signed a*s
   localparam int QRR_W  = Q_W + RR_W + 1;
   localparam int CP2_W  = 2 * CPM_W + 1;
   localparam int DIVN_W = Q_W + QUO_W;

   // side data from the setup stage to the discriminant stage
   typedef struct packed {
      logic [CW-1:0]  x0;
      logic [CW-1:0]  y0;
      logic           b_zero;
      logic [CW-1:0]  abs_a;
      logic [CW-1:0]  abs_b;
      logic           sign_a;
      logic           sign_b;
      logic [Q_W-1:0] q;
   } side_type;

   // carried alongside the square root and the second multiply
   typedef struct packed {
      side_type          side;
      logic [ACP_W-1:0]  neg_acp;
      logic [ACP_W-1:0]  neg_bcp;
      logic              d_neg;
   } mid_type;

   // carried alongside the dividers
   typedef struct packed {
      logic [CW-1:0] x0;
      logic [CW-1:0] y0;
      logic          b_zero;
      logic          d_neg;
      logic [3:0]    num_neg;
   } tail_type;

   // ---------------- stage 1: input register ----------------
   logic             accept;
   logic             v1_ff;
   lci_pkg::req_type req_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // ---------------- stage 2: 32x32 products ----------------
   logic                  v2_ff;
   logic signed [2*CW-1:0] ax_ff, by_ff, aa_ff, bb_ff;
   logic [RR_W-1:0]       rr_ff;
   logic [2*CW-1:0]       rr_full;
   logic signed [CW-1:0]  a2_ff, b2_ff, c2_ff, x2_ff, y2_ff;

   assign rr_full = {1'b0, req_ff.radius} * {1'b0, req_ff.radius};

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= req_ff.line_a * req_ff.centre_x;
      by_ff <= req_ff.line_b * req_ff.centre_y;
      aa_ff <= req_ff.line_a * req_ff.line_a;
      bb_ff <= req_ff.line_b * req_ff.line_b;
      rr_ff <= rr_full[RR_W-1:0];
      a2_ff <= req_ff.line_a;
      b2_ff <= req_ff.line_b;
      c2_ff <= req_ff.line_c;
      x2_ff <= req_ff.centre_x;
      y2_ff <= req_ff.centre_y;
   end

   // ---------------- stage 3: cp = c*2^F + a*x0 + b*y0, q = a^2 + b^2 ----------------
   logic                   v3_ff;
   logic signed [CP_W-1:0] cp_ff;
   logic [Q_W-1:0]         q_ff;
   logic [RR_W-1:0]        rr3_ff;
   logic signed [CW-1:0]   a3_ff, b3_ff, x3_ff, y3_ff;
   logic signed [CP_W-1:0] c_shift;

   assign c_shift = CP_W'(c2_ff) <<< FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff  <= c_shift + CP_W'(ax_ff) + CP_W'(by_ff);
      q_ff   <= Q_W'(aa_ff[2*CW-2:0]) + Q_W'(bb_ff[2*CW-2:0]);
      rr3_ff <= rr_ff;
      a3_ff  <= a2_ff;
      b3_ff  <= b2_ff;
      x3_ff  <= x2_ff;
      y3_ff  <= y2_ff;
   end

   // ---------------- stages 4..6: wide products ----------------
   logic [CP_W-1:0]   cp_abs_full;
   logic [CPM_W-1:0]  cp_mag;
   logic [CW-1:0]     a_mag3, b_mag3;
   logic              sign_cp;
   side_type          side3, side6;
   logic              v6;
   logic signed [QRR_W-1:0] qrr;
   logic signed [CP2_W-1:0] cp2;
   logic signed [ACP_W-1:0] neg_acp, neg_bcp;

   assign sign_cp     = cp_ff[CP_W-1];
   assign cp_abs_full = sign_cp ? (~cp_ff + CP_W'(1)) : cp_ff;
   assign cp_mag      = cp_abs_full[CPM_W-1:0];
   assign a_mag3      = a3_ff[CW-1] ? (~a3_ff + CW'(1)) : a3_ff;
   assign b_mag3      = b3_ff[CW-1] ? (~b3_ff + CW'(1)) : b3_ff;

   always_comb begin
      side3.x0     = x3_ff;
      side3.y0     = y3_ff;
      side3.b_zero = (b3_ff == '0);
      side3.abs_a  = a_mag3;
      side3.abs_b  = b_mag3;
      side3.sign_a = a3_ff[CW-1];
      side3.sign_b = b3_ff[CW-1];
      side3.q      = q_ff;
   end

   lci_mul #(.A_W(Q_W), .B_W(RR_W)) u_mul_qrr (
      .clock(clock), .a_mag(q_ff), .b_mag(rr3_ff), .negate(1'b0), .product(qrr)
   );

   lci_mul #(.A_W(CPM_W), .B_W(CPM_W)) u_mul_cp2 (
      .clock(clock), .a_mag(cp_mag), .b_mag(cp_mag), .negate(1'b0), .product(cp2)
   );

   // -a*cp and -b*cp: sign flips when the operand signs agree
   lci_mul #(.A_W(CW), .B_W(CPM_W)) u_mul_acp (
      .clock(clock), .a_mag(a_mag3), .b_mag(cp_mag),
      .negate(~(a3_ff[CW-1] ^ sign_cp)), .product(neg_acp)
   );

   lci_mul #(.A_W(CW), .B_W(CPM_W)) u_mul_bcp (
      .clock(clock), .a_mag(b_mag3), .b_mag(cp_mag),
      .negate(~(b3_ff[CW-1] ^ sign_cp)), .product(neg_bcp)
   );

   lci_delay #(.WIDTH($bits(side_type)), .DEPTH(lci_pkg::MUL_LAT)) u_dly_side (
      .clock(clock), .reset(reset), .valid_in(v3_ff), .data_in(side3),
      .valid_out(v6), .data_out(side6)
   );

   // ---------------- stage 7: discriminant ----------------
   logic                  v7_ff;
   logic signed [D_W-1:0] d_full;
   logic [2*ROOT_W-1:0]   d_mag_ff;
   mid_type               mid7_ff, mid70, mid73;
   logic                  v70, v73;

   assign d_full = D_W'(qrr) - cp2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6;
      end
   end

   always_ff @(posedge clock) begin
      d_mag_ff        <= d_full[2*ROOT_W-1:0];
      mid7_ff.side    <= side6;
      mid7_ff.neg_acp <= neg_acp;
      mid7_ff.neg_bcp <= neg_bcp;
      mid7_ff.d_neg   <= d_full[D_W-1];
   end

   // ---------------- square root ----------------
   logic [ROOT_W-1:0] root;

   lci_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
      .clock(clock), .radicand(d_mag_ff), .root(root)
   );

   lci_delay #(.WIDTH($bits(mid_type)), .DEPTH(ROOT_W)) u_dly_root (
      .clock(clock), .reset(reset), .valid_in(v7_ff), .data_in(mid7_ff),
      .valid_out(v70), .data_out(mid70)
   );

   // ---------------- |b|*s and sign(b)*a*s ----------------
   logic signed [AS_W-1:0] bs, as_signed;

   lci_mul #(.A_W(CW), .B_W(ROOT_W)) u_mul_bs (
      .clock(clock), .a_mag(mid70.side.abs_b), .b_mag(root), .negate(1'b0),
      .product(bs)
   );

   lci_mul #(.A_W(CW), .B_W(ROOT_W)) u_mul_as (
      .clock(clock), .a_mag(mid70.side.abs_a), .b_mag(root),
      .negate(mid70.side.sign_a ^ mid70.side.sign_b), .product(as_signed)
   );

   lci_delay #(.WIDTH($bits(mid_type)), .DEPTH(lci_pkg::MUL_LAT)) u_dly_prod (
      .clock(clock), .reset(reset), .valid_in(v70), .data_in(mid70),
      .valid_out(v73), .data_out(mid73)
   );

   // ---------------- numerators ----------------
   logic                    v74_ff;
   logic signed [NUM_W-1:0] num_ff [4];
   logic signed [NUM_W-1:0] num_in [4];
   logic [Q_W-1:0]          q74_ff;
   tail_type                tail74_ff, tail106;
   logic signed [NUM_W-1:0] acp_ext, bcp_ext, bs_ext, as_ext;

   assign acp_ext = NUM_W'($signed(mid73.neg_acp));
   assign bcp_ext = NUM_W'($signed(mid73.neg_bcp));
   assign bs_ext  = NUM_W'(bs);
   assign as_ext  = NUM_W'(as_signed);

   // order: first x, second x, first y, second y
   assign num_in[0] = acp_ext + bs_ext;
   assign num_in[1] = acp_ext - bs_ext;
   assign num_in[2] = bcp_ext - as_ext;
   assign num_in[3] = bcp_ext + as_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         v74_ff <= 1'b0;
      end else begin
         v74_ff <= v73;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         num_ff[k] <= num_in[k];
      end
      q74_ff            <= mid73.side.q;
      tail74_ff.x0      <= mid73.side.x0;
      tail74_ff.y0      <= mid73.side.y0;
      tail74_ff.b_zero  <= mid73.side.b_zero;
      tail74_ff.d_neg   <= mid73.d_neg;
      tail74_ff.num_neg <= {num_in[3][NUM_W-1], num_in[2][NUM_W-1],
                            num_in[1][NUM_W-1], num_in[0][NUM_W-1]};
   end

   // ---------------- dividers ----------------
   logic [QUO_W-1:0] quo [4];
   logic [3:0]       num_neg;
   logic             v106;

   assign num_neg = tail74_ff.num_neg;

   for (genvar n = 0; n < 4; n++) begin : g_div
      logic [NUM_W-1:0] num_abs;

      assign num_abs = num_neg[n] ? (~num_ff[n] + NUM_W'(1)) : num_ff[n];

      lci_div #(.QUO_W(QUO_W), .DEN_W(Q_W)) u_div (
         .clock(clock), .dividend(num_abs[DIVN_W-1:0]), .divisor(q74_ff),
         .quotient(quo[n])
      );
   end

   lci_delay #(.WIDTH($bits(tail_type)), .DEPTH(QUO_W)) u_dly_div (
      .clock(clock), .reset(reset), .valid_in(v74_ff), .data_in(tail74_ff),
      .valid_out(v106), .data_out(tail106)
   );

   // ---------------- output stage ----------------
   logic [CW+1:0]    offs [4];
   logic [CW+1:0]    x0_ext, y0_ext;
   logic [CW:0]      clip_fx, clip_fy, clip_sx, clip_sy;
   lci_pkg::rsp_type rsp_in, rsp_data_ff;
   logic             rsp_strobe_ff;

   assign x0_ext = (CW+2)'($signed(tail106.x0));
   assign y0_ext = (CW+2)'($signed(tail106.y0));

   for (genvar n = 0; n < 4; n++) begin : g_offs
      logic [CW+1:0] quo_ext;

      assign quo_ext = (CW+2)'(quo[n]);
      assign offs[n] = tail106.num_neg[n] ? (~quo_ext + (CW+2)'(1)) : quo_ext;
   end

   assign clip_fx = lci_pkg::clip_coord(x0_ext + offs[0]);
   assign clip_sx = lci_pkg::clip_coord(x0_ext + offs[1]);
   assign clip_fy = lci_pkg::clip_coord(y0_ext + offs[2]);
   assign clip_sy = lci_pkg::clip_coord(y0_ext + offs[3]);

   always_comb begin
      rsp_in.status    = lci_pkg::STATUS_NONE;
      rsp_in.first_x   = lci_pkg::COORD_NONE;
      rsp_in.first_y   = lci_pkg::COORD_NONE;
      rsp_in.second_x  = lci_pkg::COORD_NONE;
      rsp_in.second_y  = lci_pkg::COORD_NONE;
      rsp_in.saturated = 1'b0;
      if (tail106.b_zero) begin
         rsp_in.status = lci_pkg::STATUS_VERTICAL;
      end else if (!tail106.d_neg) begin
         rsp_in.first_x = clip_fx[CW-1:0];
         rsp_in.first_y = clip_fy[CW-1:0];
         if (offs[0] == offs[1]) begin
            // tangent: second point repeats the first
            rsp_in.status    = lci_pkg::STATUS_TANGENT;
            rsp_in.second_x  = clip_fx[CW-1:0];
            rsp_in.second_y  = clip_fy[CW-1:0];
            rsp_in.saturated = clip_fx[CW] | clip_fy[CW];
         end else begin
            rsp_in.status    = lci_pkg::STATUS_TWO;
            rsp_in.second_x  = clip_sx[CW-1:0];
            rsp_in.second_y  = clip_sy[CW-1:0];
            rsp_in.saturated = clip_fx[CW] | clip_fy[CW] | clip_sx[CW] | clip_sy[CW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= v106;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
